// ===== rtl/core/lzc_pkg.sv =====
// Shared types and constants for the index stream LZ compressor.
`timescale 1ns / 1ps

package lzc_pkg;

  localparam int IDX_W   = 15;  // uncompressed index word
  localparam int CODE_W  = 16;  // compressed word
  localparam int POS_W   = 13;  // loop position and compressed positions
  localparam int START_W = 12;  // start field of a reference
  localparam int LEN_W   = 3;   // length field of a reference
  localparam int MIN_REF = 2;   // shortest run emitted as a reference

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic REF_FLAG = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_CMP,
    S_LIT,
    S_EMIT
  } lzc_state_t;

endpackage

// ===== rtl/core/lzc_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module lzc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/index_stream_lz_compressor.sv =====
// Greedy longest-match LZ compressor for a stream of 15-bit index words.
`timescale 1ns / 1ps

// A load (in_opcode 0) appends in_index_word to the input store unless that
// store is full. A fetch (in_opcode 1) parses at the current input position
// and, unless the parse is finished or the output store is full, emits one
// word on out_code_word with out_valid high for exactly one cycle; the
// receiver must take it then. The fetch searches every word emitted so far
// with one comparator fed by a single read port on each store. Each compared
// word passes through S_CHECK (address), then S_CMP (compare). A run that
// stops at the end of either store is ended in S_CHECK, which moves on to the
// next start. After the closing check comes S_EMIT, with S_LIT before it for
// a literal. Busy is high from S_CHECK through S_EMIT, and the word appears
// in the first cycle with busy low again. A fetch that gives no word leaves
// busy low. out_loop_outer stays 0 until the configured loop position has
// been consumed, then holds until reset.
// cfg_ready is always high; write cfg_loop_position only while busy is low.
module index_stream_lz_compressor
  import lzc_pkg::*;
#(
  parameter int MAX_WORDS = 4096,
  parameter int MAX_MATCH = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_opcode,
  input  logic [IDX_W-1:0]    in_index_word,
  output logic                out_valid,
  output logic [CODE_W-1:0]   out_code_word,
  output logic                out_is_last,
  output logic [POS_W-1:0]    out_loop_outer,
  output logic [START_W-1:0]  out_loop_inner,
  output logic [POS_W-1:0]    out_loop_segment_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [POS_W-1:0]    cfg_loop_position
);

  localparam int AW    = $clog2(MAX_WORDS);
  localparam int CW    = $clog2(MAX_WORDS + 1);
  localparam int CMP_W = POS_W + 1;

  lzc_state_t state_r, state_nxt;

  logic [CW-1:0] in_cnt_r, in_cnt_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] out_cnt_r, out_cnt_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] in_addr_r, in_addr_nxt;
  logic [CW-1:0] out_addr_r, out_addr_nxt;
  logic [CW-1:0] best_len_r, best_len_nxt;
  logic [CW-1:0] best_start_r, best_start_nxt;

  logic [POS_W-1:0]   loop_pos_r;
  logic [POS_W-1:0]   loop_outer_r, loop_outer_nxt;
  logic [START_W-1:0] loop_inner_r, loop_inner_nxt;
  logic [POS_W-1:0]   loop_end_r, loop_end_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              last_r, last_nxt;

  logic [IDX_W-1:0]  in_rdata;
  logic [CODE_W-1:0] out_rdata;
  logic              in_wr_en;
  logic              out_wr_en;

  logic          load_acc;
  logic          fetch_ok;
  logic          scan_done;
  logic          in_bounds;
  logic          word_eq;
  logic          is_ref;
  logic [CW-1:0] run_len;
  logic [CW-1:0] cap_len;
  logic [CW-1:0] used;
  logic [CW:0]   new_pos;
  logic [CODE_W-1:0] word;
  logic [POS_W-1:0]  outer_new;
  logic [POS_W-1:0]  depth;

  assign load_acc  = start && !busy && (in_opcode == OP_LOAD);
  assign fetch_ok  = start && !busy && (in_opcode == OP_FETCH) &&
                     (pos_r < in_cnt_r) && (out_cnt_r < CW'(MAX_WORDS));
  assign scan_done = (j_r == out_cnt_r);
  assign in_bounds = (in_addr_r < in_cnt_r) && (out_addr_r < out_cnt_r);
  assign word_eq   = (out_rdata == {1'b0, in_rdata});
  assign is_ref    = (best_len_r >= CW'(MIN_REF));
  assign run_len   = k_r + CW'(1);
  assign cap_len   = (best_len_r > CW'(MAX_MATCH)) ? CW'(MAX_MATCH) : best_len_r;
  assign used      = is_ref ? cap_len : CW'(1);
  assign new_pos   = {1'b0, pos_r} + {1'b0, used};
  assign word      = is_ref ? {REF_FLAG, LEN_W'(cap_len - CW'(MIN_REF)),
                               START_W'(best_start_r)}
                            : {1'b0, in_rdata};
  assign outer_new = POS_W'(out_cnt_r) + POS_W'(1);
  assign depth     = loop_pos_r - POS_W'(pos_r);

  lzc_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_WORDS)
  ) u_in_ram (
    .clk     (clk),
    .wr_en   (in_wr_en),
    .wr_addr (in_cnt_r[AW-1:0]),
    .wr_data (in_index_word),
    .rd_addr (in_addr_r[AW-1:0]),
    .rd_data (in_rdata)
  );

  lzc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_WORDS)
  ) u_out_ram (
    .clk     (clk),
    .wr_en   (out_wr_en),
    .wr_addr (out_cnt_r[AW-1:0]),
    .wr_data (word),
    .rd_addr (out_addr_r[AW-1:0]),
    .rd_data (out_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (fetch_ok) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (scan_done) begin
          state_nxt = is_ref ? S_EMIT : S_LIT;
        end else if (in_bounds) begin
          state_nxt = S_CMP;
        end
      end
      S_CMP:  state_nxt = S_CHECK;
      S_LIT:  state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    busy      = (state_r != S_IDLE);
    in_wr_en  = load_acc && (in_cnt_r < CW'(MAX_WORDS));
    out_wr_en = (state_r == S_EMIT);
  end

  // Datapath
  always_comb begin
    in_cnt_nxt     = in_cnt_r;
    pos_nxt        = pos_r;
    out_cnt_nxt    = out_cnt_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    in_addr_nxt    = in_addr_r;
    out_addr_nxt   = out_addr_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    loop_outer_nxt = loop_outer_r;
    loop_inner_nxt = loop_inner_r;
    loop_end_nxt   = loop_end_r;
    code_nxt       = code_r;
    last_nxt       = last_r;
    out_valid_nxt  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_wr_en) begin
          in_cnt_nxt = in_cnt_r + CW'(1);
        end
        if (fetch_ok) begin
          j_nxt          = '0;
          k_nxt          = '0;
          out_addr_nxt   = '0;
          in_addr_nxt    = pos_r;
          best_len_nxt   = '0;
          best_start_nxt = '0;
        end
      end
      S_CHECK: begin
        if (scan_done) begin
          // point the input read at the literal word
          in_addr_nxt = pos_r;
        end else if (!in_bounds) begin
          j_nxt        = j_r + CW'(1);
          out_addr_nxt = j_r + CW'(1);
          in_addr_nxt  = pos_r;
          k_nxt        = '0;
        end
      end
      S_CMP: begin
        if (word_eq) begin
          if (run_len > best_len_r) begin
            best_len_nxt   = run_len;
            best_start_nxt = j_r;
          end
          k_nxt        = run_len;
          in_addr_nxt  = in_addr_r + CW'(1);
          out_addr_nxt = out_addr_r + CW'(1);
        end else begin
          j_nxt        = j_r + CW'(1);
          out_addr_nxt = j_r + CW'(1);
          in_addr_nxt  = pos_r;
          k_nxt        = '0;
        end
      end
      S_EMIT: begin
        out_cnt_nxt   = out_cnt_r + CW'(1);
        pos_nxt       = CW'(new_pos);
        code_nxt      = word;
        last_nxt      = (CW'(new_pos) >= in_cnt_r);
        out_valid_nxt = 1'b1;
        if ((loop_outer_r == '0) && (CMP_W'(new_pos) > {1'b0, loop_pos_r})) begin
          loop_outer_nxt = outer_new;
          if (is_ref) begin
            loop_inner_nxt = START_W'(POS_W'(best_start_r) + depth);
            loop_end_nxt   = POS_W'(best_start_r) + POS_W'(used);
          end else begin
            loop_inner_nxt = START_W'(outer_new - POS_W'(1));
            loop_end_nxt   = outer_new;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_cnt_r     <= '0;
      pos_r        <= '0;
      out_cnt_r    <= '0;
      loop_pos_r   <= '0;
      loop_outer_r <= '0;
      loop_inner_r <= '0;
      loop_end_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_cnt_r     <= in_cnt_nxt;
      pos_r        <= pos_nxt;
      out_cnt_r    <= out_cnt_nxt;
      loop_outer_r <= loop_outer_nxt;
      loop_inner_r <= loop_inner_nxt;
      loop_end_r   <= loop_end_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        loop_pos_r <= cfg_loop_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r          <= j_nxt;
    k_r          <= k_nxt;
    in_addr_r    <= in_addr_nxt;
    out_addr_r   <= out_addr_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    code_r       <= code_nxt;
    last_r       <= last_nxt;
  end

  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_code_word        = code_r;
  assign out_is_last          = last_r;
  assign out_loop_outer       = loop_outer_r;
  assign out_loop_inner       = loop_inner_r;
  assign out_loop_segment_end = loop_end_r;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held longer than one cycle");

  a_parse_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r <= in_cnt_r) && (out_cnt_r <= CW'(MAX_WORDS)))
    else $error("parse position or output count out of range");

  a_loop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (loop_outer_r != '0) |=> $stable(loop_outer_r))
    else $error("loop position changed after it was recorded");

  a_emit_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |=> (out_cnt_r == $past(out_cnt_r) + CW'(1)) && out_valid_r)
    else $error("emitted word did not advance the output count");
`endif

endmodule
